/* hw/rtl/fpr_pkg.sv */
`default_nettype none

package fpr_pkg;

	localparam int unsigned HEADER_BYTES = 7;
	localparam int unsigned CRC_BYTES    = 2;
	localparam int unsigned CNT_W        = 17;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	localparam logic [7:0]  START_RESET = 8'd27;
	localparam logic [7:0]  TOKEN_RESET = 8'd14;
	localparam logic [15:0] MAXLEN_RESET = 16'd512;

	typedef enum logic [1:0] {
		REG_START_BYTE = 2'd0,
		REG_TOKEN_BYTE = 2'd1,
		REG_MAX_BODY   = 2'd2,
		REG_UNUSED     = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_HEAD = 2'd1,
		PH_BODY = 2'd2,
		PH_CRC  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_TOKEN = 2'd1,
		ST_TOO_LONG  = 2'd2,
		ST_BAD_CRC   = 2'd3
	} status_t;

	typedef enum logic {
		KIND_BODY = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  token_byte;
		logic [15:0] max_body_len;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [15:0] body_index;
		logic [1:0]  status;
		logic [15:0] seq_number;
		logic [15:0] body_length;
	} result_t;

	// reflected CRC-16-CCITT, one byte
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/fpr_if.sv */
`default_nettype none

interface fpr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [15:0] body_index;
	logic [1:0]  status;
	logic [15:0] seq_number;
	logic [15:0] body_length;

	modport source (output valid, output kind, output data_byte, output body_index,
		output status, output seq_number, output body_length, input ready);
	modport sink   (input valid, input kind, input data_byte, input body_index,
		input status, input seq_number, input body_length, output ready);
endinterface

interface fpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fpr_cfg.sv */
`default_nettype none

module fpr_cfg
	import fpr_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	fpr_cfg_if.sink cfg,
	output cfg_t cfg_regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs  = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.start_byte   <= START_RESET;
			regs_q.token_byte   <= TOKEN_RESET;
			regs_q.max_body_len <= MAXLEN_RESET;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_START_BYTE: regs_q.start_byte   <= cfg.data[7:0];
				REG_TOKEN_BYTE: regs_q.token_byte   <= cfg.data[7:0];
				REG_MAX_BODY:   regs_q.max_body_len <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/fpr_in_stage.sv */
`default_nettype none

module fpr_in_stage
	import fpr_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	fpr_rx_if.sink     rx,
	input  wire        take,
	output logic       s1_valid,
	output logic [7:0] s1_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// take a new item whenever the held one leaves or the stage is empty
	assign rx.ready = !valid_s1 || take;
	assign s1_valid = valid_s1;
	assign s1_byte  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/fpr_core.sv */
`default_nettype none

module fpr_core
	import fpr_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  cfg_t       cfg_regs,
	input  wire        s1_valid,
	input  wire  [7:0] s1_byte,
	output logic       take,
	fpr_res_if.source  res
);

	phase_t             phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [15:0]        crc_q, crc_d;
	logic [15:0]        seq_q, seq_d;
	logic [31:0]        len_q, len_d;
	result_t            res_q, res_d;
	logic               res_valid_q, emit;

	logic [15:0]        crc_new;
	logic [CNT_W-1:0]   cnt_inc;
	logic               hdr_done, crc_done, body_done;
	logic               bad_token, too_long;
	logic [15:0]        len16;

	assign take = s1_valid && (!res_valid_q || res.ready);

	// the length is complete before the token byte, so len_q is final when judged
	assign crc_new   = crc_step((phase_q == PH_HUNT) ? CRC_INIT : crc_q, s1_byte);
	assign cnt_inc   = cnt_q + 1'b1;
	assign hdr_done  = cnt_inc >= CNT_W'(HEADER_BYTES);
	assign crc_done  = cnt_inc >= CNT_W'(CRC_BYTES);
	assign body_done = {15'd0, cnt_inc} >= len_q;
	assign bad_token = s1_byte != cfg_regs.token_byte;
	assign too_long  = len_q > {16'd0, cfg_regs.max_body_len};
	assign len16     = (|len_q[31:16]) ? 16'hFFFF : len_q[15:0];

	// next state
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		seq_d   = seq_q;
		len_d   = len_q;
		if (take) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (s1_byte == cfg_regs.start_byte) begin
						crc_d   = crc_new;
						cnt_d   = '0;
						seq_d   = '0;
						len_d   = '0;
						phase_d = PH_HEAD;
					end
				end
				PH_HEAD: begin
					crc_d = crc_new;
					cnt_d = cnt_inc;
					unique case (cnt_q[2:0])
						3'd0: seq_d[7:0]   = s1_byte;
						3'd1: seq_d[15:8]  = s1_byte;
						3'd2: len_d[7:0]   = s1_byte;
						3'd3: len_d[15:8]  = s1_byte;
						3'd4: len_d[23:16] = s1_byte;
						3'd5: len_d[31:24] = s1_byte;
						default: ;
					endcase
					if (hdr_done) begin
						cnt_d = '0;
						if (bad_token || too_long) begin
							phase_d = PH_HUNT;
						end else begin
							phase_d = (len_q == 32'd0) ? PH_CRC : PH_BODY;
						end
					end
				end
				PH_BODY: begin
					crc_d = crc_new;
					cnt_d = cnt_inc;
					if (body_done) begin
						cnt_d   = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					crc_d = crc_new;
					cnt_d = cnt_inc;
					if (crc_done) begin
						cnt_d   = '0;
						phase_d = PH_HUNT;
					end
				end
				default: ;
			endcase
		end
	end

	// result for the item in hand
	always_comb begin
		emit              = 1'b0;
		res_d.kind        = KIND_END;
		res_d.data_byte   = '0;
		res_d.body_index  = '0;
		res_d.status      = ST_OK;
		res_d.seq_number  = seq_d;
		res_d.body_length = len16;
		unique case (phase_q)
			PH_HUNT: ;
			PH_HEAD: begin
				if (hdr_done) begin
					priority if (bad_token) begin
						emit         = 1'b1;
						res_d.status = ST_BAD_TOKEN;
					end else if (too_long) begin
						emit         = 1'b1;
						res_d.status = ST_TOO_LONG;
					end
				end
			end
			PH_BODY: begin
				emit             = 1'b1;
				res_d.kind       = KIND_BODY;
				res_d.data_byte  = s1_byte;
				res_d.body_index = cnt_q[15:0];
			end
			PH_CRC: begin
				if (crc_done) begin
					emit         = 1'b1;
					res_d.status = (crc_new == 16'd0) ? ST_OK : ST_BAD_CRC;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			crc_q       <= CRC_INIT;
			seq_q       <= '0;
			len_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			if (take) begin
				res_valid_q <= emit;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_d;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.kind        = res_q.kind;
	assign res.data_byte   = res_q.data_byte;
	assign res.body_index  = res_q.body_index;
	assign res.status      = res_q.status;
	assign res.seq_number  = res_q.seq_number;
	assign res.body_length = res_q.body_length;

endmodule

`default_nettype wire

/* hw/rtl/framed_packet_receiver_crc16.sv */
// Framed packet receiver with reflected CRC-16-CCITT check.
//
// rx  : one received byte per item (valid/ready). Bytes are hunted for the
//       start byte, then a 7-byte header (sequence, 32-bit length, token),
//       the body and two CRC bytes follow.
// res : one item per body byte (kind body, with its index) and one frame-end
//       item per frame carrying status: ok, bad token, too long or bad crc.
// cfg : register writes (0 start byte, 1 token byte, 2 max body length);
//       always ready, write only while the block is idle.
// Path: a byte passes the input register, then the result register.
// Throughput is one byte per cycle while the result register is empty or
// being taken; the critical loop is the CRC byte update feeding the phase step.
// Stall: every byte, with or without a result, leaves the input register only
// while the result register is empty or being taken. While the result waits
// on res.ready, one more byte is held in the input register; rx.ready then
// drops until the result leaves.
// Reset: hunting, CRC at 0xFFFF, registers at their reset values, both
// stages empty.
`default_nettype none

module framed_packet_receiver_crc16
	import fpr_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	fpr_rx_if.sink    rx,
	fpr_res_if.source res,
	fpr_cfg_if.sink   cfg
);

	cfg_t       cfg_regs;
	logic       s1_valid;
	logic [7:0] s1_byte;
	logic       take;

	// hold the configuration registers
	fpr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	// register the incoming byte; acts as the skid slot while res stalls
	fpr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.s1_valid (s1_valid),
		.s1_byte  (s1_byte)
	);

	// advance the frame state and build the result
	fpr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_regs),
		.s1_valid (s1_valid),
		.s1_byte  (s1_byte),
		.take     (take),
		.res      (res)
	);

	// a held byte stays put until the core takes it
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !take |=> s1_valid && $stable(s1_byte))
		else $error("input stage lost or changed a held byte");

	// rx only stalls with a byte already waiting
	a_rx_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> s1_valid)
		else $error("rx stalled with empty input stage");

	// body items always carry ok status
	a_body_status: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.kind == KIND_BODY) |-> res.status == ST_OK)
		else $error("body item with non-ok status");

	// never take a byte while the result register is blocked
	a_take_ok: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> s1_valid && (!res.valid || res.ready))
		else $error("byte taken while result register blocked");

endmodule

`default_nettype wire
